// File: hw/rtl/qpsk_symbol_modulator_defines.svh
// Assertion macros used by the checker file of the QPSK symbol modulator.
`ifndef QPSK_SYMBOL_MODULATOR_DEFINES_SVH
`define QPSK_SYMBOL_MODULATOR_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define QSM_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define QSM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hw/rtl/qsm_pkg.sv
// Types, constants and table functions for the QPSK symbol modulator.
package qsm_pkg;

	localparam int QSM_MAX_SPS   = 64;
	localparam int QSM_SINE_BITS = 8;

	localparam int PHASE_W = 32;
	localparam int SPS_W   = 7;
	localparam int AMP_W   = 31;
	localparam int MAG_W   = 15;
	localparam int SMP_W   = 32;
	localparam int IDX_REG_W = 2;

	// Register indexes of the configuration port.
	localparam logic [IDX_REG_W-1:0] CFG_PHASE_STEP = 2'd0;
	localparam logic [IDX_REG_W-1:0] CFG_SPS        = 2'd1;
	localparam logic [IDX_REG_W-1:0] CFG_AMPLITUDE  = 2'd2;

	localparam logic [PHASE_W-1:0] RST_PHASE_STEP = 32'd102261126;
	localparam logic [SPS_W-1:0]   RST_SPS        = 7'd42;
	localparam logic [AMP_W-1:0]   RST_AMPLITUDE  = 31'd2130706432;

	// Symbol codes.
	localparam logic [1:0] SYM_00 = 2'b00;
	localparam logic [1:0] SYM_01 = 2'b01;
	localparam logic [1:0] SYM_10 = 2'b10;
	localparam logic [1:0] SYM_11 = 2'b11;

	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
	localparam logic [63:0] Q30_ONE     = 64'd1 << 30;

	typedef struct packed {
		logic [PHASE_W-1:0] phase_step;
		logic [SPS_W-1:0]   samples_per_symbol;
		logic [AMP_W-1:0]   amplitude;
	} cfg_t;

	typedef struct packed {
		logic               vld;
		logic [PHASE_W-1:0] angle;
		logic               last;
	} smp_req_t;

	// Phase offset in eighths of a turn for each symbol.
	function automatic logic [2:0] phase_octant(input logic [1:0] sym);
		logic [2:0] k;
		case (sym)
			SYM_00:  k = 3'd3;
			SYM_01:  k = 3'd1;
			SYM_10:  k = 3'd5;
			SYM_11:  k = 3'd7;
			default: k = 3'd3;
		endcase
		return k;
	endfunction

	// One quarter-wave entry in unsigned Q0.15, built from a Q30 Taylor series through x^11.
	function automatic logic [MAG_W-1:0] sine_entry(input int unsigned i,
			input int unsigned bits);
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] t;
		logic [63:0] s;
		logic [63:0] r;
		x  = (64'(i) * HALF_PI_Q30) >> bits;
		x2 = (x * x) >> 30;
		t  = Q30_ONE;
		t  = Q30_ONE - (((x2 * t) >> 30) / 110);
		t  = Q30_ONE - (((x2 * t) >> 30) / 72);
		t  = Q30_ONE - (((x2 * t) >> 30) / 42);
		t  = Q30_ONE - (((x2 * t) >> 30) / 20);
		t  = Q30_ONE - (((x2 * t) >> 30) / 6);
		s  = (x * t) >> 30;
		r  = (s * 64'd32767 + (64'd1 << 29)) >> 30;
		return r[MAG_W-1:0];
	endfunction

endpackage

// File: hw/rtl/qsm_cfg.sv
// Configuration register file: carrier step, samples per symbol and amplitude.
module qsm_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [qsm_pkg::IDX_REG_W-1:0] cfg_index,
	input  logic [31:0]                   cfg_data,
	output qsm_pkg::cfg_t                 cfg
);
	import qsm_pkg::*;

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.phase_step         <= RST_PHASE_STEP;
			cfg_q.samples_per_symbol <= RST_SPS;
			cfg_q.amplitude          <= RST_AMPLITUDE;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_PHASE_STEP: cfg_q.phase_step         <= cfg_data[PHASE_W-1:0];
				CFG_SPS:        cfg_q.samples_per_symbol <= cfg_data[SPS_W-1:0];
				CFG_AMPLITUDE:  cfg_q.amplitude          <= cfg_data[AMP_W-1:0];
				default: ;
			endcase
		end
	end

endmodule

// File: hw/rtl/qsm_seq.sv
// Symbol sequencer: holds the current symbol and issues one carrier angle per cycle while the datapath advances.
module qsm_seq #(
	parameter int MAX_SAMPLES_PER_SYMBOL = qsm_pkg::QSM_MAX_SPS
) (
	input  logic              clk,
	input  logic              arst_n,
	input  qsm_pkg::cfg_t     cfg,
	input  logic              sym_valid,
	output logic              sym_stall,
	input  logic [1:0]        symbol_bits,
	input  logic              advance,
	output qsm_pkg::smp_req_t req
);
	import qsm_pkg::*;

	localparam int CNT_W = (MAX_SAMPLES_PER_SYMBOL > 1) ? $clog2(MAX_SAMPLES_PER_SYMBOL) : 1;

	logic               busy_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [CNT_W-1:0]   last_idx_q;
	logic [2:0]         oct_q;
	logic [PHASE_W-1:0] phase_q;

	logic             emit;
	logic             finish;
	logic             accept;
	logic [SPS_W-1:0] n_sat;

	always_comb begin
		emit      = busy_q & advance;
		finish    = emit & (cnt_q == last_idx_q);
		sym_stall = busy_q & ~finish;
		accept    = sym_valid & ~sym_stall;
	end

	// A count of zero means one sample; counts above the maximum are capped.
	always_comb begin
		if (cfg.samples_per_symbol == '0) begin
			n_sat = SPS_W'(1);
		end else if (cfg.samples_per_symbol > SPS_W'(MAX_SAMPLES_PER_SYMBOL)) begin
			n_sat = SPS_W'(MAX_SAMPLES_PER_SYMBOL);
		end else begin
			n_sat = cfg.samples_per_symbol;
		end
	end

	always_comb begin
		req.vld   = emit;
		req.angle = phase_q + {oct_q, {(PHASE_W-3){1'b0}}};
		req.last  = (cnt_q == last_idx_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			cnt_q   <= '0;
			phase_q <= '0;
		end else begin
			if (emit) begin
				phase_q <= phase_q + cfg.phase_step;
			end
			if (accept) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (finish) begin
				busy_q <= 1'b0;
				cnt_q  <= '0;
			end else if (emit) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			oct_q      <= phase_octant(symbol_bits);
			last_idx_q <= CNT_W'(n_sat - SPS_W'(1));
		end
	end

endmodule

// File: hw/rtl/qsm_dp.sv
// Sample datapath: quarter-wave sine lookup, amplitude product, rounding and sign.
module qsm_dp #(
	parameter int SINE_TABLE_BITS = qsm_pkg::QSM_SINE_BITS
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic [qsm_pkg::AMP_W-1:0]         amplitude,
	input  qsm_pkg::smp_req_t                 req,
	output logic                              advance,
	output logic                              smp_valid,
	input  logic                              smp_stall,
	output logic signed [qsm_pkg::SMP_W-1:0]  sample,
	output logic                              last_of_symbol
);
	import qsm_pkg::*;

	localparam int N     = 1 << SINE_TABLE_BITS;
	localparam int IDX_W = SINE_TABLE_BITS + 1;
	localparam int PRD_W = AMP_W + MAG_W;

	logic [MAG_W-1:0] lut [0:N];

	for (genvar g = 0; g <= N; g++) begin : g_lut
		localparam logic [MAG_W-1:0] V = sine_entry(g, SINE_TABLE_BITS);
		assign lut[g] = V;
	end

	logic               v_s1, v_s2, v_s3, v_q;
	logic [PHASE_W-1:0] ang_s1;
	logic               last_s1, last_s2, last_s3, last_q;
	logic [MAG_W-1:0]   mag_s2;
	logic               neg_s2, neg_s3;
	logic [AMP_W-1:0]   p_s3;
	logic [SMP_W-1:0]   sample_q;

	logic [SINE_TABLE_BITS-1:0] fine;
	logic [IDX_W-1:0]           idx;
	logic [PRD_W-1:0]           prod;
	logic [PRD_W-1:0]           rnd;

	// The whole pipeline holds while the output word waits on a stalled receiver.
	assign advance = ~v_q | ~smp_stall;

	always_comb begin
		fine = ang_s1[PHASE_W-3 -: SINE_TABLE_BITS];
		if (ang_s1[PHASE_W-2]) begin
			idx = IDX_W'(N) - {1'b0, fine};
		end else begin
			idx = {1'b0, fine};
		end
		prod = PRD_W'(amplitude) * PRD_W'(mag_s2);
		rnd  = prod + PRD_W'(1 << (MAG_W - 1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_q  <= 1'b0;
		end else if (advance) begin
			v_s1 <= req.vld;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_q  <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			ang_s1  <= req.angle;
			last_s1 <= req.last;
			mag_s2  <= lut[idx];
			neg_s2  <= ang_s1[PHASE_W-1];
			last_s2 <= last_s1;
			p_s3    <= rnd[PRD_W-1 -: AMP_W];
			neg_s3  <= neg_s2;
			last_s3 <= last_s2;
			if (neg_s3) begin
				sample_q <= SMP_W'(0) - {1'b0, p_s3};
			end else begin
				sample_q <= {1'b0, p_s3};
			end
			last_q <= last_s3;
		end
	end

	assign smp_valid      = v_q;
	assign sample         = sample_q;
	assign last_of_symbol = last_q;

endmodule

// File: hw/rtl/qpsk_symbol_modulator.sv
// Top level of the QPSK symbol modulator.
//
// Symbol channel: sym_valid / sym_stall carry one two-bit word, symbol_bits.
// Sample channel: smp_valid / smp_stall carry sample (signed) and last_of_symbol.
// A word moves at a clock edge where valid is high and stall is low.
// Configuration: cfg_valid / cfg_ready with cfg_index and cfg_data; cfg_ready
// is always high. Index 0 is the phase step, 1 samples per symbol, 2 amplitude.
// Each symbol yields samples_per_symbol samples (0 acts as 1, capped at the maximum),
// one per cycle while the receiver does not stall, the last one flagged. A symbol holds
// the sequencer until its last sample issues; the next one is taken at the edge that
// issues the last sample of the current one, so symbols stream without gaps.
// A taken symbol's first sample passes through stages s1, s2, s3 and the output register.
// The carrier phase runs on across symbols and is only cleared by reset.
// Reset clears the phase, the pipeline and the registers to their defaults.
// While the receiver stalls a valid output word, the pipeline freezes and that word holds; an idle
// sequencer still takes one new symbol and waits with it.
module qpsk_symbol_modulator #(
	parameter int MAX_SAMPLES_PER_SYMBOL = qsm_pkg::QSM_MAX_SPS,
	parameter int SINE_TABLE_BITS        = qsm_pkg::QSM_SINE_BITS
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [qsm_pkg::IDX_REG_W-1:0]    cfg_index,
	input  logic [31:0]                      cfg_data,
	input  logic                             sym_valid,
	output logic                             sym_stall,
	input  logic [1:0]                       symbol_bits,
	output logic                             smp_valid,
	input  logic                             smp_stall,
	output logic signed [qsm_pkg::SMP_W-1:0] sample,
	output logic                             last_of_symbol
);
	import qsm_pkg::*;

	cfg_t     cfg;
	smp_req_t req;
	logic     advance;

	qsm_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	qsm_seq #(
		.MAX_SAMPLES_PER_SYMBOL(MAX_SAMPLES_PER_SYMBOL)
	) u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.sym_valid   (sym_valid),
		.sym_stall   (sym_stall),
		.symbol_bits (symbol_bits),
		.advance     (advance),
		.req         (req)
	);

	qsm_dp #(
		.SINE_TABLE_BITS(SINE_TABLE_BITS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.amplitude      (cfg.amplitude),
		.req            (req),
		.advance        (advance),
		.smp_valid      (smp_valid),
		.smp_stall      (smp_stall),
		.sample         (sample),
		.last_of_symbol (last_of_symbol)
	);

endmodule

// File: hw/rtl/qsm_checker.sv
// Port-level checker for the QPSK symbol modulator, bound to the top level.
`include "qpsk_symbol_modulator_defines.svh"

module qsm_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             cfg_valid,
	input logic                             cfg_ready,
	input logic                             sym_valid,
	input logic                             sym_stall,
	input logic [1:0]                       symbol_bits,
	input logic                             smp_valid,
	input logic                             smp_stall,
	input logic signed [qsm_pkg::SMP_W-1:0] sample,
	input logic                             last_of_symbol
);

	logic                    smp_held;
	logic                    sym_held;
	logic                    idle_no_sym;
	logic [qsm_pkg::SMP_W:0] smp_word;

	assign smp_held    = smp_valid & smp_stall;
	assign sym_held    = sym_valid & sym_stall;
	assign idle_no_sym = ~sym_stall & ~sym_valid;
	assign smp_word    = {sample, last_of_symbol};

	// A stalled sample word stays on the port unchanged.
	`QSM_ASSERT_NEXT(a_smp_hold, clk, arst_n, smp_held, smp_valid && $stable(smp_word), "stalled sample moved")

	// With nothing in hand and nothing offered, the symbol side stays open.
	`QSM_ASSERT_NEXT(a_idle_stays, clk, arst_n, idle_no_sym, !sym_stall, "symbol stall rose while idle")

	// Register writes are never back-pressured.
	`QSM_ASSERT_SAME(a_cfg_ready, clk, arst_n, cfg_valid, cfg_ready, "configuration write refused")

	// A symbol word that waits on a stall stays offered and unchanged.
	`QSM_ASSERT_NEXT(a_sym_hold, clk, arst_n, sym_held, sym_valid && $stable(symbol_bits), "stalled symbol moved")

endmodule

bind qpsk_symbol_modulator qsm_checker u_qsm_checker (.*);
